// ===== rtl/core/range_flip_count_tree_assert.svh =====
// ---------------------------------------------------------------------------
// Range flip count tree assertion macros
// Clocked assertion macros shared by the RTL; they compile to nothing when
// ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef RANGE_FLIP_COUNT_TREE_ASSERT_SVH
`define RANGE_FLIP_COUNT_TREE_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge out of reset.
`define RFCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never be seen at a clock edge out of reset.
`define RFCT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RFCT_ASSERT(label, clk, rst_n, prop, msg)
`define RFCT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/rfct_pkg.sv =====
// ---------------------------------------------------------------------------
// Range flip count tree package
// Shared widths, codes, state and command/status types for the lazy
// segment tree block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfct_pkg;

    // Fixed field widths of the streaming and configuration interfaces.
    localparam int unsigned ELEMENTS_DEFAULT = 65536;
    localparam int unsigned LEN_W            = 17;
    localparam int unsigned OP_W             = 2;
    localparam int unsigned POS_IN_W         = 16;
    localparam int unsigned COUNT_OUT_W      = 17;
    localparam logic [LEN_W-1:0] LEN_RESET   = 17'd65536;

    // Operation codes carried in tuser.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FLIP  = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

    // Progress of a stack frame through its children.
    localparam logic [1:0] PH_ENTER      = 2'd0;
    localparam logic [1:0] PH_FIRST_DONE = 2'd1;
    localparam logic [1:0] PH_BOTH_DONE  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ENTER,
        ST_ACT,
        ST_POP,
        ST_RET,
        ST_RSM_L,
        ST_RSM_R,
        ST_RSM_W,
        ST_SUB_RD,
        ST_SUB_EV,
        ST_SUB_TL,
        ST_SUB_TR,
        ST_FIN
    } state_t;

    // Which node the settle unit works on, relative to the top frame.
    typedef enum logic [1:0] {
        SUB_TOP,
        SUB_LEFT,
        SUB_RIGHT
    } sub_sel_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_LEFT,
        PUSH_RIGHT,
        PUSH_POS
    } push_t;

    typedef struct packed {
        logic     clr_step;
        logic     start;
        logic     sub_begin;
        sub_sel_t sub_sel;
        logic     sub_force;
        logic     sub_rd;
        logic     sub_eval;
        logic     sub_tl;
        logic     sub_tr;
        logic     acc_add;
        logic     leaf_write;
        push_t    push;
        logic     pop;
        logic     save_left;
        logic     resum_write;
        logic     out_load;
    } rfct_cmd_t;

    typedef struct packed {
        logic            clr_last;
        logic [OP_W-1:0] op;
        logic            load_ok;
        logic            disjoint;
        logic            covered;
        logic            leaf;
        logic            root;
        logic [1:0]      phase;
        logic            sub_toggle;
        logic            out_busy;
    } rfct_status_t;

endpackage

// ===== rtl/core/range_flip_count_tree.sv =====
// ---------------------------------------------------------------------------
// Range flip count tree
// Bit array held as a lazy segment tree with range flip, range count and
// single-position load.
// ---------------------------------------------------------------------------
// Channel     Direction  tdata fields (low bit first)               tuser
// s_axis      in         range_low, range_high, load_value, pad     operation
// m_axis      out        ones_count, pad                            -
// cfg_wr      in         length_in_use (no handshake, write only)   -
//
// One transaction at a time; a count result waits in an output register
// while the next transaction is taken. A transaction walks the tree
// depth-first with a frame stack, bound by the single read and write
// port of node memory; flips and counts visit up to four nodes per
// level. After reset the node memory is cleared in one sweep of all
// 2 * 2^ceil(log2 ELEMENTS) words (131072 by default) before any
// transaction is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "range_flip_count_tree_assert.svh"

module range_flip_count_tree
    import rfct_pkg::*;
#(
    parameter int unsigned ELEMENTS = ELEMENTS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,  // range_low, range_high, load_value
    input  logic [1:0]       s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata   // ones_count
);

    rfct_cmd_t              cmd;
    rfct_status_t           st;
    logic [COUNT_OUT_W-1:0] ones;

    // Controller.
    rfct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath.
    rfct_dp #(
        .ELEMENTS (ELEMENTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_op       (s_axis_tuser),
        .in_lo       (s_axis_tdata[15:0]),
        .in_hi       (s_axis_tdata[31:16]),
        .in_val      (s_axis_tdata[32]),
        .cmd         (cmd),
        .st          (st),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ones    (ones)
    );

    assign m_axis_tdata = {7'd0, ones};

    // A new result is never loaded over one still waiting.
    `RFCT_ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && m_axis_tvalid, "result overwritten")
    // No memory traffic while the block offers to take a transaction.
    `RFCT_ASSERT(a_idle_quiet, clk, rst_n, s_axis_tready |-> !(cmd.sub_rd || cmd.sub_eval || cmd.leaf_write || cmd.resum_write), "memory busy while ready")
    // The frame stack never pops its root.
    `RFCT_ASSERT_NEVER(a_no_underflow, clk, rst_n, cmd.pop && st.root, "stack underflow")

endmodule

// ===== rtl/core/rfct_dp.sv =====
// ---------------------------------------------------------------------------
// Range flip count tree datapath
// Node memory, frame stack, settle unit, accumulator and result register,
// all driven by commands from the controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfct_dp
    import rfct_pkg::*;
#(
    parameter int unsigned ELEMENTS = ELEMENTS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LEN_W-1:0]       cfg_wr_data,
    input  logic [OP_W-1:0]        in_op,
    input  logic [POS_IN_W-1:0]    in_lo,
    input  logic [POS_IN_W-1:0]    in_hi,
    input  logic                   in_val,
    input  rfct_cmd_t              cmd,
    output rfct_status_t           st,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [COUNT_OUT_W-1:0] out_ones
);

    localparam int unsigned PW  = $clog2(ELEMENTS);
    localparam int unsigned AW  = PW + 1;
    localparam int unsigned DEPTH = 2 ** AW;
    localparam int unsigned NW  = $clog2(ELEMENTS + 1);
    localparam int unsigned CW  = (NW > COUNT_OUT_W) ? NW : COUNT_OUT_W;
    localparam int unsigned XW  = (PW > POS_IN_W) ? PW : POS_IN_W;
    localparam int unsigned MW  = CW + 1;
    localparam int unsigned SD  = PW + 1;
    localparam int unsigned SPW = $clog2(SD);

    // Configuration and latched transaction.
    logic [LEN_W-1:0]  len_reg;
    logic [OP_W-1:0]   op_reg;
    logic [XW-1:0]     lo_in_reg;
    logic [XW-1:0]     hi_in_reg;
    logic              val_reg;
    logic [NW-1:0]     span_n;

    // Frame stack.
    logic [AW-1:0]     stk_node_reg [SD];
    logic [PW-1:0]     stk_lo_reg   [SD];
    logic [PW-1:0]     stk_hi_reg   [SD];
    logic [1:0]        stk_ph_reg   [SD];
    logic [SPW-1:0]    top_reg;
    logic [SPW-1:0]    top_up;
    logic [AW-1:0]     t_node;
    logic [PW-1:0]     t_lo;
    logic [PW-1:0]     t_hi;
    logic [PW:0]       t_sum;
    logic [PW-1:0]     t_mid;
    logic [PW-1:0]     t_mid_up;
    logic [AW-1:0]     t_left;
    logic [AW-1:0]     t_right;
    logic              pos_left;

    // Settle unit.
    logic [AW-1:0]     sub_node_reg;
    logic [PW-1:0]     sub_lo_reg;
    logic [PW-1:0]     sub_hi_reg;
    logic              sub_force_reg;
    logic [CW-1:0]     sub_ones_reg;
    logic [AW-1:0]     sub_left;
    logic [AW-1:0]     sub_right;
    logic [CW-1:0]     sub_len;
    logic              do_inv;
    logic [CW-1:0]     inv_ones;

    // Node memory and its ports.
    logic [MW-1:0]     mem [DEPTH];
    logic [MW-1:0]     rd_data_reg;
    logic              rd_p;
    logic [CW-1:0]     rd_ones;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MW-1:0]     wr_data;
    logic [AW-1:0]     clr_addr_reg;

    logic [CW-1:0]     acc_reg;
    logic [CW-1:0]     left_ones_reg;
    logic              out_valid_reg;
    logic [COUNT_OUT_W-1:0] out_ones_reg;

    // Length register; the user must write it only while idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_reg <= cfg_wr_data;
        end
    end

    // Effective number of positions: zero acts as one, larger values clamp.
    always_comb
    begin
        if (len_reg == '0)
        begin
            span_n = NW'(1);
        end
        else if (32'(len_reg) > 32'(ELEMENTS))
        begin
            span_n = NW'(ELEMENTS);
        end
        else
        begin
            span_n = NW'(len_reg);
        end
    end

    // Capture the accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= in_op;
            lo_in_reg <= XW'(in_lo);
            hi_in_reg <= XW'(in_hi);
            val_reg   <= in_val;
        end
    end

    // Top frame and the spans of its children.
    assign t_node   = stk_node_reg[top_reg];
    assign t_lo     = stk_lo_reg[top_reg];
    assign t_hi     = stk_hi_reg[top_reg];
    assign t_sum    = {1'b0, t_lo} + {1'b0, t_hi};
    assign t_mid    = t_sum[PW:1];
    assign t_mid_up = t_mid + PW'(1);
    assign t_left   = {t_node[AW-2:0], 1'b0};
    assign t_right  = {t_node[AW-2:0], 1'b1};
    assign pos_left = lo_in_reg <= XW'(t_mid);
    assign top_up   = top_reg + SPW'(1);

    // Stack pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else if (cmd.start)
        begin
            top_reg <= '0;
        end
        else if (cmd.push != PUSH_NONE)
        begin
            top_reg <= top_up;
        end
        else if (cmd.pop)
        begin
            top_reg <= top_reg - SPW'(1);
        end
    end

    // Frame contents: the root on start, a child on push.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            stk_node_reg[0] <= AW'(1);
            stk_lo_reg[0]   <= '0;
            stk_hi_reg[0]   <= PW'(span_n - NW'(1));
            stk_ph_reg[0]   <= PH_ENTER;
        end
        else if (cmd.push != PUSH_NONE)
        begin
            stk_ph_reg[top_reg] <= stk_ph_reg[top_reg] + 2'd1;
            stk_ph_reg[top_up]  <= PH_ENTER;
            case (cmd.push)
                PUSH_LEFT:
                begin
                    stk_node_reg[top_up] <= t_left;
                    stk_lo_reg[top_up]   <= t_lo;
                    stk_hi_reg[top_up]   <= t_mid;
                end
                PUSH_RIGHT:
                begin
                    stk_node_reg[top_up] <= t_right;
                    stk_lo_reg[top_up]   <= t_mid_up;
                    stk_hi_reg[top_up]   <= t_hi;
                end
                default:
                begin
                    stk_node_reg[top_up] <= pos_left ? t_left : t_right;
                    stk_lo_reg[top_up]   <= pos_left ? t_lo : t_mid_up;
                    stk_hi_reg[top_up]   <= pos_left ? t_mid : t_hi;
                end
            endcase
        end
    end

    // Settle unit: target selection and settled count.
    assign sub_left  = {sub_node_reg[AW-2:0], 1'b0};
    assign sub_right = {sub_node_reg[AW-2:0], 1'b1};
    assign sub_len   = CW'(sub_hi_reg - sub_lo_reg) + CW'(1);
    assign rd_p      = rd_data_reg[CW];
    assign rd_ones   = rd_data_reg[CW-1:0];
    assign do_inv    = sub_force_reg | rd_p;
    assign inv_ones  = sub_len - rd_ones;

    always_ff @(posedge clk)
    begin
        if (cmd.sub_begin)
        begin
            sub_force_reg <= cmd.sub_force;
            unique case (cmd.sub_sel)
                SUB_LEFT:
                begin
                    sub_node_reg <= t_left;
                    sub_lo_reg   <= t_lo;
                    sub_hi_reg   <= t_mid;
                end
                SUB_RIGHT:
                begin
                    sub_node_reg <= t_right;
                    sub_lo_reg   <= t_mid_up;
                    sub_hi_reg   <= t_hi;
                end
                default:
                begin
                    sub_node_reg <= t_node;
                    sub_lo_reg   <= t_lo;
                    sub_hi_reg   <= t_hi;
                end
            endcase
        end
        if (cmd.sub_eval)
        begin
            sub_ones_reg <= do_inv ? inv_ones : rd_ones;
        end
        if (cmd.save_left)
        begin
            left_ones_reg <= sub_ones_reg;
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + sub_ones_reg;
        end
    end

    // Memory port selection.
    always_comb
    begin
        rd_en   = cmd.sub_rd | cmd.sub_eval | cmd.sub_tl;
        rd_addr = sub_node_reg;
        if (cmd.sub_eval)
        begin
            rd_addr = sub_left;
        end
        else if (cmd.sub_tl)
        begin
            rd_addr = sub_right;
        end

        wr_en   = 1'b0;
        wr_addr = sub_node_reg;
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
        end
        else if (cmd.sub_eval)
        begin
            wr_en   = do_inv;
            wr_data = {1'b0, inv_ones};
        end
        else if (cmd.sub_tl)
        begin
            wr_en   = 1'b1;
            wr_addr = sub_left;
            wr_data = {~rd_p, rd_ones};
        end
        else if (cmd.sub_tr)
        begin
            wr_en   = 1'b1;
            wr_addr = sub_right;
            wr_data = {~rd_p, rd_ones};
        end
        else if (cmd.leaf_write)
        begin
            wr_en   = 1'b1;
            wr_addr = t_node;
            wr_data = {1'b0, CW'(val_reg)};
        end
        else if (cmd.resum_write)
        begin
            wr_en   = 1'b1;
            wr_addr = t_node;
            wr_data = {1'b0, left_ones_reg + sub_ones_reg};
        end
    end

    // Node memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Clearing sweep address after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Result register, parting the output from the tree walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_ones_reg <= acc_reg[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ones  = out_ones_reg;

    // Status back to the controller.
    always_comb
    begin
        st.clr_last   = &clr_addr_reg;
        st.op         = op_reg;
        st.load_ok    = 32'(lo_in_reg) < 32'(span_n);
        st.disjoint   = (XW'(t_lo) > hi_in_reg) || (XW'(t_hi) < lo_in_reg);
        st.covered    = (XW'(t_lo) >= lo_in_reg) && (XW'(t_hi) <= hi_in_reg);
        st.leaf       = t_lo == t_hi;
        st.root       = top_reg == '0;
        st.phase      = stk_ph_reg[top_reg];
        st.sub_toggle = do_inv && (sub_lo_reg != sub_hi_reg);
        st.out_busy   = out_valid_reg;
    end

endmodule

// ===== rtl/core/rfct_ctrl.sv =====
// ---------------------------------------------------------------------------
// Range flip count tree controller
// Sequences the clearing sweep and the depth-first tree walk of one
// transaction, including the settle subroutine on node memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfct_ctrl
    import rfct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  rfct_status_t st,
    output rfct_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;

    // State and subroutine return registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                case (st.op)
                    OP_LOAD:  state_next = st.load_ok ? ST_ENTER : ST_IDLE;
                    OP_FLIP:  state_next = ST_ENTER;
                    OP_COUNT: state_next = ST_ENTER;
                    default:  state_next = ST_IDLE;
                endcase
            end

            // A count skips nodes outside its range without settling them.
            ST_ENTER:
            begin
                if (st.op == OP_COUNT && st.disjoint)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.sub_begin = 1'b1;
                    cmd.sub_sel   = SUB_TOP;
                    ret_next      = ST_ACT;
                    state_next    = ST_SUB_RD;
                end
            end

            ST_ACT:
            begin
                case (st.op)
                    OP_LOAD:
                    begin
                        if (st.leaf)
                        begin
                            cmd.leaf_write = 1'b1;
                            state_next     = ST_POP;
                        end
                        else
                        begin
                            cmd.push   = PUSH_POS;
                            state_next = ST_ENTER;
                        end
                    end
                    OP_FLIP:
                    begin
                        if (st.disjoint)
                        begin
                            state_next = ST_POP;
                        end
                        else if (st.covered)
                        begin
                            cmd.sub_begin = 1'b1;
                            cmd.sub_sel   = SUB_TOP;
                            cmd.sub_force = 1'b1;
                            ret_next      = ST_POP;
                            state_next    = ST_SUB_RD;
                        end
                        else
                        begin
                            cmd.push   = PUSH_LEFT;
                            state_next = ST_ENTER;
                        end
                    end
                    default:
                    begin
                        if (st.covered)
                        begin
                            cmd.acc_add = 1'b1;
                            state_next  = ST_POP;
                        end
                        else
                        begin
                            cmd.push   = PUSH_LEFT;
                            state_next = ST_ENTER;
                        end
                    end
                endcase
            end

            ST_POP:
            begin
                if (st.root)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_RET;
                end
            end

            // Back in a parent frame after one of its children finished.
            ST_RET:
            begin
                case (st.op)
                    OP_LOAD:
                    begin
                        state_next = ST_RSM_L;
                    end
                    OP_FLIP:
                    begin
                        if (st.phase == PH_FIRST_DONE)
                        begin
                            cmd.push   = PUSH_RIGHT;
                            state_next = ST_ENTER;
                        end
                        else
                        begin
                            state_next = ST_RSM_L;
                        end
                    end
                    default:
                    begin
                        if (st.phase == PH_FIRST_DONE)
                        begin
                            cmd.push   = PUSH_RIGHT;
                            state_next = ST_ENTER;
                        end
                        else
                        begin
                            state_next = ST_POP;
                        end
                    end
                endcase
            end

            // Rebuild a node's count from its two settled children.
            ST_RSM_L:
            begin
                cmd.sub_begin = 1'b1;
                cmd.sub_sel   = SUB_LEFT;
                ret_next      = ST_RSM_R;
                state_next    = ST_SUB_RD;
            end

            ST_RSM_R:
            begin
                cmd.save_left = 1'b1;
                cmd.sub_begin = 1'b1;
                cmd.sub_sel   = SUB_RIGHT;
                ret_next      = ST_RSM_W;
                state_next    = ST_SUB_RD;
            end

            ST_RSM_W:
            begin
                cmd.resum_write = 1'b1;
                state_next      = ST_POP;
            end

            // Settle subroutine: read, invert if marked or forced, pass mark to children.
            ST_SUB_RD:
            begin
                cmd.sub_rd = 1'b1;
                state_next = ST_SUB_EV;
            end

            ST_SUB_EV:
            begin
                cmd.sub_eval = 1'b1;
                state_next   = st.sub_toggle ? ST_SUB_TL : ret_reg;
            end

            ST_SUB_TL:
            begin
                cmd.sub_tl = 1'b1;
                state_next = ST_SUB_TR;
            end

            ST_SUB_TR:
            begin
                cmd.sub_tr = 1'b1;
                state_next = ret_reg;
            end

            ST_FIN:
            begin
                if (st.op != OP_COUNT)
                begin
                    state_next = ST_IDLE;
                end
                else if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
